FILE: src/npmv_pkg.sv
// Package: types, constants and the byte realignment function of the majority vote decoder.
package npmv_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_nibble;
    typedef logic [1:0] t_sym_count;

    // Reset value of the error symbol: ASCII 'E'.
    localparam t_byte ERR_SYMBOL_RESET = 8'h45;

    // Count of the symbol that triggers the vote (third symbol, counted from zero).
    localparam t_sym_count VOTE_SYMBOL = 2'd2;

    // Shift right until bits 7..5 are clear, then keep the low nibble.
    // The leading one decides the shift: bit 7 -> 3, bit 6 -> 2, bit 5 -> 1.
    function automatic t_nibble realign_nibble(input t_byte b);
        t_byte shifted;
        if (b[7]) begin
            shifted = b >> 3;
        end else if (b[6]) begin
            shifted = b >> 2;
        end else if (b[5]) begin
            shifted = b >> 1;
        end else begin
            shifted = b;
        end
        return shifted[3:0];
    endfunction

endpackage

FILE: src/npmv_if.sv
// Interfaces: input byte channel and decoded result channel.
interface npmv_in_if
    import npmv_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte raw_byte;

    modport source (output valid, output raw_byte, input ready);
    modport sink   (input valid, input raw_byte, output ready);
endinterface

interface npmv_out_if
    import npmv_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte decoded_byte;
    logic  vote_failed;

    modport source (output valid, output decoded_byte, output vote_failed, input ready);
    modport sink   (input valid, input decoded_byte, input vote_failed, output ready);
endinterface

FILE: src/nibble_pair_majority_vote_decoder_unit.sv
// Top level: realigns link bytes, pairs nibbles into symbols and votes every three symbols.
//
// The block takes one received link byte per item and realigns it: the byte is shifted
// right until bits 7..5 are clear, and its low nibble is kept. Two bytes make one symbol
// (first byte high nibble, second byte low nibble), and every three symbols give one
// result item: the value that at least two symbols share (checked 0/1, then 1/2, then
// 0/2), or the programmed error symbol with vote_failed set when all three differ. So
// six input items make one result item; the other five make none. Rate: one item per
// clock while the input is not stalled. The sixth byte passes from the input register
// through the realignment and the three symbol compares into the result register in a
// single pass. The result register frees the input side from a stalled sink; the input
// stalls only when the result register is still full and the item in the input register
// would produce a new result. The error symbol register resets to 'E' and is written
// through i_cfg_we / i_cfg_data; the user must write it only while the block is idle,
// as the block itself does not enforce this.
module nibble_pair_majority_vote_decoder_unit
    import npmv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    npmv_in_if.sink       i_in,
    npmv_out_if.source    o_out,
    input  logic          i_cfg_we,
    input  t_byte         i_cfg_data
);

    // Configuration
    t_byte      r_err_symbol;

    // Input register
    logic       r_in_valid;
    t_byte      r_in_byte;

    // Decode state
    logic       r_second_half;
    t_nibble    r_held_high;
    t_sym_count r_sym_cnt;
    t_byte      r_earlier [2];

    // Result register
    logic       r_out_valid;
    t_byte      r_out_byte;
    logic       r_out_failed;

    t_nibble    nib;
    t_byte      sym;
    logic       produces;
    logic       out_free;
    logic       adv;
    logic       in_ready;
    t_byte      n_out_byte;
    logic       n_out_failed;

    always_comb begin
        nib      = realign_nibble(r_in_byte);
        sym      = {r_held_high, nib};
        // The second byte of the third symbol closes a vote.
        produces = r_second_half && (r_sym_cnt == VOTE_SYMBOL);
        out_free = !r_out_valid || o_out.ready;
        adv      = r_in_valid && (!produces || out_free);
        in_ready = !r_in_valid || adv;

        n_out_failed = 1'b0;
        if (r_earlier[0] == r_earlier[1]) begin
            n_out_byte = r_earlier[0];
        end else if (r_earlier[1] == sym) begin
            n_out_byte = r_earlier[1];
        end else if (r_earlier[0] == sym) begin
            n_out_byte = r_earlier[0];
        end else begin
            n_out_byte   = r_err_symbol;
            n_out_failed = 1'b1;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.decoded_byte = r_out_byte;
    assign o_out.vote_failed  = r_out_failed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_symbol <= ERR_SYMBOL_RESET;
        end else if (i_cfg_we) begin
            r_err_symbol <= i_cfg_data;
        end
    end

    // Input register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_second_half <= 1'b0;
            r_held_high   <= '0;
            r_sym_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end

            if (adv) begin
                if (!r_second_half) begin
                    r_held_high   <= nib;
                    r_second_half <= 1'b1;
                end else begin
                    r_held_high   <= '0;
                    r_second_half <= 1'b0;
                    if (produces) begin
                        r_sym_cnt <= '0;
                    end else begin
                        r_sym_cnt <= r_sym_cnt + 2'd1;
                    end
                end
            end

            if (adv && produces) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_in_byte <= i_in.raw_byte;
        end
        // First and second symbols are stored until the vote.
        if (adv && r_second_half && !produces) begin
            r_earlier[r_sym_cnt[0]] <= sym;
        end
        if (adv && produces) begin
            r_out_byte   <= n_out_byte;
            r_out_failed <= n_out_failed;
        end
    end

endmodule

FILE: src/npmv_checker.sv
// Checker: port-level assertions for the majority vote decoder, bound to the top level.
module npmv_checker
    import npmv_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_byte i_out_byte,
    input logic  i_out_failed,
    input logic  i_cfg_we,
    input t_byte i_cfg_data
);

    t_byte      r_err_mirror;
    logic [2:0] r_byte_cnt;
    logic [1:0] r_pending;
    logic       in_fire;
    logic       out_fire;
    logic       sixth;

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;
    assign sixth    = in_fire && (r_byte_cnt == 3'd5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_mirror <= ERR_SYMBOL_RESET;
            r_byte_cnt   <= '0;
            r_pending    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_err_mirror <= i_cfg_data;
            end
            if (in_fire) begin
                r_byte_cnt <= sixth ? 3'd0 : r_byte_cnt + 3'd1;
            end
            r_pending <= r_pending + {1'b0, sixth} - {1'b0, out_fire};
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_failed))
        else $error("result changed while stalled");

    // A result only after its sixth byte, at most two in flight
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("result without six input bytes");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2)
        else $error("too many votes in flight");

    // Failed vote carries the programmed error symbol
    a_err_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_failed |-> i_out_byte == r_err_mirror)
        else $error("failed vote without error symbol");

    // Empty result register never stalls the input
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind nibble_pair_majority_vote_decoder_unit npmv_checker u_npmv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.decoded_byte),
    .i_out_failed (o_out.vote_failed),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_data   (i_cfg_data)
);
